@@ hdl/polynomial_horner_evaluate_assert.svh @@
// Assertion helpers used by the evaluator's step module.
// They expect signals named clock and reset in the scope where they are used.
`ifndef POLYNOMIAL_HORNER_EVALUATE_ASSERT_SVH
`define POLYNOMIAL_HORNER_EVALUATE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PHE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PHE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/phe_pkg.sv @@
`timescale 1ns / 1ps

package phe_pkg;

   // Coefficient file and pipeline depth
   localparam int NUM_COEFS       = 7;
   localparam int NUM_STEPS       = 6;
   localparam int DEGREE_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic [DEGREE_WIDTH-1:0]    degree_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   // Highest degree supported; the unused code above it is clamped to this
   localparam degree_type MAX_DEGREE = degree_type'(6);

   // Register map
   localparam csr_index_type REG_DEGREE = csr_index_type'(0);
   localparam csr_index_type REG_COEF_0 = csr_index_type'(1);

   // Control bits that travel with each item through the pipeline
   typedef struct packed {
      logic valid;
      logic sat;
   } phe_ctl_type;

endpackage

@@ hdl/phe_step.sv @@
`timescale 1ns / 1ps
`include "polynomial_horner_evaluate_assert.svh"

// One Horner step over two register stages:
//   stage A: full product acc * x
//   stage B: arithmetic shift, add coefficient, saturate
// An inactive step (index at or above the degree) passes the value through.
module phe_step #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       active,
   input  logic [DATA_WIDTH-1:0]      coef,
   input  phe_pkg::phe_ctl_type       up_ctl,
   input  logic [DATA_WIDTH-1:0]      up_acc,
   input  logic [DATA_WIDTH-1:0]      up_x,
   output logic                       up_ready,
   output phe_pkg::phe_ctl_type       dn_ctl,
   output logic [DATA_WIDTH-1:0]      dn_acc,
   output logic [DATA_WIDTH-1:0]      dn_x,
   input  logic                       dn_ready
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int SW = PW + 1;
   localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   phe_pkg::phe_ctl_type    ctl_a_ff, ctl_b_ff, ctl_b_in;
   logic [DATA_WIDTH-1:0]   acc_a_ff, x_a_ff, acc_b_ff, x_b_ff, acc_b_in;
   logic signed [PW-1:0]    prod_a_ff, prod_in, quot;
   logic [SW-1:0]           sum;
   logic                    ovf;
   logic                    ready_a, ready_b;

   // Stage readiness: a stage takes new data when empty or draining
   assign ready_b  = !ctl_b_ff.valid || dn_ready;
   assign ready_a  = !ctl_a_ff.valid || ready_b;
   assign up_ready = ready_a;

   // Stage A: signed full-width product
   assign prod_in = $signed({{DATA_WIDTH{up_acc[DATA_WIDTH-1]}}, up_acc})
                  * $signed({{DATA_WIDTH{up_x[DATA_WIDTH-1]}}, up_x});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else if (ready_a) begin
         ctl_a_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         acc_a_ff  <= up_acc;
         x_a_ff    <= up_x;
         prod_a_ff <= prod_in;
      end
   end

   // Stage B: floor shift, add, saturate to the data range
   assign quot = prod_a_ff >>> FRAC_BITS;
   assign sum  = {quot[PW-1], quot}
               + {{(SW-DATA_WIDTH){coef[DATA_WIDTH-1]}}, coef};
   // in range only when the bits from the top down to the result sign bit all agree
   assign ovf  = !((&sum[SW-1:DATA_WIDTH-1]) || !(|sum[SW-1:DATA_WIDTH-1]));

   always_comb begin
      ctl_b_in.valid = ctl_a_ff.valid;
      ctl_b_in.sat   = ctl_a_ff.sat | (active & ovf);
      if (!active) begin
         acc_b_in = acc_a_ff;
      end else if (ovf) begin
         acc_b_in = sum[SW-1] ? MIN_VAL : MAX_VAL;
      end else begin
         acc_b_in = sum[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else if (ready_b) begin
         ctl_b_ff <= ctl_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         acc_b_ff <= acc_b_in;
         x_b_ff   <= x_a_ff;
      end
   end

   assign dn_ctl = ctl_b_ff;
   assign dn_acc = acc_b_ff;
   assign dn_x   = x_b_ff;

   // Checks
   `PHE_ASSERT_NEXT(a_bypass_keeps_acc, ready_b && ctl_a_ff.valid && !active, acc_b_ff == $past(acc_a_ff), "inactive step changed the value")
   `PHE_ASSERT_NEXT(a_sat_sticky, ready_b && ctl_a_ff.valid && ctl_a_ff.sat, ctl_b_ff.sat, "saturation flag lost")
   `PHE_ASSERT_NEXT(a_bypass_no_sat, ready_b && ctl_a_ff.valid && !active && !ctl_a_ff.sat, !ctl_b_ff.sat, "inactive step raised saturation")
   `PHE_ASSERT_SAME(a_stall_needs_full_b, ctl_a_ff.valid && !ready_a, ctl_b_ff.valid && !dn_ready, "stage A stalled behind an empty stage")

endmodule

@@ hdl/polynomial_horner_evaluate.sv @@
`timescale 1ns / 1ps

// Horner polynomial evaluator, signed fixed point (Q16.16 by default). Each x taken on
// req_ yields one result c_d*x^d + ... + c_0 on rsp_, where every active step floors the product
// by FRAC_BITS, adds the next coefficient and saturates; rsp_tuser flags any saturation.
// Degree 7 acts as 6. The datapath is a fixed chain of six steps of two stages each plus
// an entry stage whatever the degree, and one item is taken per cycle while rsp_tready
// does not stall the chain; each step's 2*DATA_WIDTH-bit multiply sets the clock. Write degree and
// coefficients on csr_ only while the pipeline is empty.
module polynomial_horner_evaluate #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // fields from bit 0: x_value
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]       req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // fields from bit 0: poly_value
   output logic [((DATA_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   // fields from bit 0: saturated
   output logic                                  rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_we,
   input  logic [phe_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [DATA_WIDTH-1:0]                 csr_wdata
);

   localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int NS          = phe_pkg::NUM_STEPS;

   phe_pkg::degree_type    degree_ff, deg_clamp;
   logic [DATA_WIDTH-1:0]  coef_ff [phe_pkg::NUM_COEFS];

   phe_pkg::phe_ctl_type   ctl_s [NS+1];
   logic [DATA_WIDTH-1:0]  acc_s [NS+1];
   logic [DATA_WIDTH-1:0]  x_s   [NS+1];
   logic                   rdy_s [NS+1];
   logic [NS-1:0]          step_active;

   phe_pkg::phe_ctl_type   ctl_e_ff, ctl_e_in;
   logic [DATA_WIDTH-1:0]  acc_e_ff, x_e_ff;
   logic                   ready_e;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         for (int i = 0; i < phe_pkg::NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            phe_pkg::REG_DEGREE: begin
               degree_ff <= csr_wdata[phe_pkg::DEGREE_WIDTH-1:0];
            end
            default: begin
               coef_ff[csr_index - phe_pkg::REG_COEF_0] <= csr_wdata;
            end
         endcase
      end
   end

   assign deg_clamp = (degree_ff > phe_pkg::MAX_DEGREE) ? phe_pkg::MAX_DEGREE : degree_ff;

   // Entry stage: latch x and seed the accumulator with the top coefficient
   assign ready_e    = !ctl_e_ff.valid || rdy_s[0];
   assign req_tready = ready_e;
   assign ctl_e_in   = '{valid: req_tvalid, sat: 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_e_ff <= '0;
      end else if (ready_e) begin
         ctl_e_ff <= ctl_e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_e) begin
         x_e_ff   <= req_tdata[DATA_WIDTH-1:0];
         acc_e_ff <= coef_ff[deg_clamp];
      end
   end

   assign ctl_s[0] = ctl_e_ff;
   assign acc_s[0] = acc_e_ff;
   assign x_s[0]   = x_e_ff;
   assign rdy_s[NS] = rsp_tready;

   // Step k handles coefficient index NS-1-k; it works only below the degree
   for (genvar k = 0; k < NS; k++) begin : g_step
      localparam phe_pkg::degree_type STEP_N = phe_pkg::degree_type'(NS - 1 - k);

      assign step_active[k] = (deg_clamp > STEP_N);

      phe_step #(
         .DATA_WIDTH (DATA_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .active   (step_active[k]),
         .coef     (coef_ff[NS - 1 - k]),
         .up_ctl   (ctl_s[k]),
         .up_acc   (acc_s[k]),
         .up_x     (x_s[k]),
         .up_ready (rdy_s[k]),
         .dn_ctl   (ctl_s[k+1]),
         .dn_acc   (acc_s[k+1]),
         .dn_x     (x_s[k+1]),
         .dn_ready (rdy_s[k+1])
      );
   end

   // Last step's stage B is the output register
   assign rsp_tvalid = ctl_s[NS].valid;
   assign rsp_tuser  = ctl_s[NS].sat;
   assign rsp_tdata  = TDATA_WIDTH'(acc_s[NS]);

endmodule
